[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/auprem_pkg.sv]
package auprem_pkg;

	// Queue between the classifier and the adjust pipeline
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Register port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic [0:0]  REG_IDX_PREMUL_EN = 1'b0;

	// Request commands
	localparam logic CMD_ANALYZE = 1'b0;
	localparam logic CMD_ADJUST  = 1'b1;

	// Alpha classification
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_ADJUST = 2'd1;
	localparam logic [1:0] MODE_PREMUL = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} matte_t;

	// One adjust request, classified and ready for the back end
	typedef struct packed {
		pixel_t     pix;
		matte_t     matte;
		logic [1:0] mode;
		logic       premul_en;
	} job_t;

	// Matte share to remove: (m * (a ^ 0xFF)) >> 8
	function automatic logic [7:0] matte_share(input logic [7:0] m, input logic [7:0] a);
		logic [15:0] p;
		p = {8'd0, m} * {8'd0, a ^ ALPHA_OPAQUE};
		return p[15:8];
	endfunction

	// Subtract the matte share, floor at zero, clamp to alpha
	function automatic logic [7:0] unmatte(input logic [7:0] c, input logic [7:0] sub,
			input logic [7:0] a);
		logic [7:0] v;
		v = (c > sub) ? (c - sub) : 8'd0;
		return (v > a) ? a : v;
	endfunction

endpackage

[rtl/auprem_front.sv]
module auprem_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 command,
	input  logic                 first_of_frame,
	input  auprem_pkg::pixel_t   pix,
	input  logic                 premul_en,
	output logic                 job_push,
	output auprem_pkg::job_t     job
);
	import auprem_pkg::*;

	logic   seen_partial_q, seen_nonempty_q, all_premul_q;
	matte_t matte_q;

	logic   base_partial, base_nonempty, base_allp;
	matte_t base_matte;
	logic   over_alpha;
	logic [1:0] mode_cur;

	// Analysis state as seen by this pixel (cleared on frame start)
	always_comb begin
		if (first_of_frame) begin
			base_partial  = 1'b0;
			base_nonempty = 1'b0;
			base_allp     = 1'b1;
			base_matte    = '0;
		end else begin
			base_partial  = seen_partial_q;
			base_nonempty = seen_nonempty_q;
			base_allp     = all_premul_q;
			base_matte    = matte_q;
		end
	end

	assign over_alpha = (pix.red > pix.alpha) || (pix.green > pix.alpha) ||
		(pix.blue > pix.alpha);

	// Analyze pass state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_partial_q  <= 1'b0;
			seen_nonempty_q <= 1'b0;
			all_premul_q    <= 1'b1;
			matte_q         <= '0;
		end else if (take && command == CMD_ANALYZE) begin
			all_premul_q <= base_allp & ~over_alpha;
			if (pix.alpha != ALPHA_CLEAR) begin
				seen_partial_q  <= base_partial | (pix.alpha != ALPHA_OPAQUE);
				seen_nonempty_q <= 1'b1;
				matte_q         <= base_matte;
			end else begin
				seen_partial_q  <= 1'b1;
				seen_nonempty_q <= base_nonempty;
				matte_q         <= '{red: pix.red, green: pix.green, blue: pix.blue};
			end
		end
	end

	// Classification from the current record
	always_comb begin
		mode_cur = MODE_NONE;
		if (seen_partial_q && seen_nonempty_q) begin
			if (matte_q.red != '0 && matte_q.green != '0 && matte_q.blue != '0 &&
					all_premul_q)
				mode_cur = MODE_PREMUL;
			else
				mode_cur = MODE_ADJUST;
		end
	end

	assign job_push      = take && command == CMD_ADJUST;
	assign job.pix       = pix;
	assign job.matte     = matte_q;
	assign job.mode      = mode_cur;
	assign job.premul_en = premul_en;

endmodule

[rtl/auprem_queue.sv]
module auprem_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  auprem_pkg::job_t  wr_data,
	input  logic              rd,
	output auprem_pkg::job_t  rd_data,
	output logic              full,
	output logic              empty
);
	import auprem_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/auprem_back.sv]
module auprem_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  auprem_pkg::job_t  job,
	output logic              job_take,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_first,
	output logic [7:0]        out_second,
	output logic [7:0]        out_third,
	output logic [7:0]        out_fourth,
	output logic [1:0]        mode
);
	import auprem_pkg::*;

	logic   v_s1, v_s2, v_s3;
	logic   rdy1, rdy2, rdy3;
	job_t   job_s1, job_s2;
	matte_t sub_s1;
	matte_t u_s2;
	logic [16:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic [7:0]  first_s3, second_s3, third_s3, fourth_s3;
	logic [1:0]  mode_s3;

	matte_t      u_c;
	logic [8:0]  a1_c;
	logic [8:0]  pv_r, pv_g, pv_b;
	logic [8:0]  a1_s2;
	logic [7:0]  fr, fg, fb;
	logic [7:0]  o1, o2, o3, o4;

	// Stall chain from the output register back to the queue
	assign rdy3     = !v_s3 || pop;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign job_take = job_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= job_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	// Stage 1: matte share per channel
	always_ff @(posedge clk) begin
		if (rdy1) begin
			job_s1       <= job;
			sub_s1.red   <= matte_share(job.matte.red, job.pix.alpha);
			sub_s1.green <= matte_share(job.matte.green, job.pix.alpha);
			sub_s1.blue  <= matte_share(job.matte.blue, job.pix.alpha);
		end
	end

	// Stage 2: unmatte and clamp, then premultiply product
	assign u_c.red   = unmatte(job_s1.pix.red, sub_s1.red, job_s1.pix.alpha);
	assign u_c.green = unmatte(job_s1.pix.green, sub_s1.green, job_s1.pix.alpha);
	assign u_c.blue  = unmatte(job_s1.pix.blue, sub_s1.blue, job_s1.pix.alpha);
	assign a1_c      = {1'b0, job_s1.pix.alpha} + 9'd1;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			job_s2    <= job_s1;
			u_s2      <= u_c;
			prod_r_s2 <= {8'd0, a1_c} * {9'd0, u_c.red};
			prod_g_s2 <= {8'd0, a1_c} * {9'd0, u_c.green};
			prod_b_s2 <= {8'd0, a1_c} * {9'd0, u_c.blue};
		end
	end

	// Stage 3: scale back, pick by mode, swizzle
	assign a1_s2 = {1'b0, job_s2.pix.alpha} + 9'd1;
	assign pv_r  = (prod_r_s2[16:8] > a1_s2) ? a1_s2 : prod_r_s2[16:8];
	assign pv_g  = (prod_g_s2[16:8] > a1_s2) ? a1_s2 : prod_g_s2[16:8];
	assign pv_b  = (prod_b_s2[16:8] > a1_s2) ? a1_s2 : prod_b_s2[16:8];

	always_comb begin
		if (job_s2.premul_en) begin
			fr = pv_r[7:0];
			fg = pv_g[7:0];
			fb = pv_b[7:0];
		end else begin
			fr = u_s2.red;
			fg = u_s2.green;
			fb = u_s2.blue;
		end
		if (job_s2.mode != MODE_ADJUST) begin
			o1 = job_s2.pix.red;
			o2 = job_s2.pix.green;
			o3 = job_s2.pix.blue;
			o4 = job_s2.pix.alpha;
		end else if (job_s2.pix.alpha == ALPHA_CLEAR) begin
			o1 = '0;
			o2 = '0;
			o3 = '0;
			o4 = '0;
		end else if (job_s2.pix.alpha == ALPHA_OPAQUE) begin
			o1 = job_s2.pix.alpha;
			o2 = job_s2.pix.red;
			o3 = job_s2.pix.green;
			o4 = job_s2.pix.blue;
		end else begin
			o1 = job_s2.pix.alpha;
			o2 = fr;
			o3 = fg;
			o4 = fb;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			first_s3  <= o1;
			second_s3 <= o2;
			third_s3  <= o3;
			fourth_s3 <= o4;
			mode_s3   <= job_s2.mode;
		end
	end

	assign empty      = !v_s3;
	assign out_first  = first_s3;
	assign out_second = second_s3;
	assign out_third  = third_s3;
	assign out_fourth = fourth_s3;
	assign mode       = mode_s3;

endmodule

[rtl/alpha_unmatte_premultiply.sv]
// An adjust request passes through the queue and the stage 1, 2 and 3 registers to the result ports,
// and is held back while pop is low. Analyze requests update the record at the accepting edge.
// Throughput: one request per cycle while full is low; the 4-entry queue and the
// 3-stage adjust pipeline set how long input keeps flowing while results are not popped.
// Reset (arst_n low, asynchronous): queue and pipeline empty, record cleared,
// premultiply_enable set to 1.
module alpha_unmatte_premultiply (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            command,
	input  logic                            first_of_frame,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      alpha,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_first,
	output logic [7:0]                      out_second,
	output logic [7:0]                      out_third,
	output logic [7:0]                      out_fourth,
	output logic [1:0]                      mode,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [auprem_pkg::APB_AW-1:0]   paddr,
	input  logic [auprem_pkg::APB_DW-1:0]   pwdata,
	output logic [auprem_pkg::APB_DW-1:0]   prdata,
	output logic                            pready
);
	import auprem_pkg::*;

	logic   premul_en_q;
	logic   take;
	logic   job_push, q_empty, q_take;
	job_t   job_in, job_out;
	pixel_t pix;

	// Register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			premul_en_q <= 1'b1;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_PREMUL_EN)
			premul_en_q <= pwdata[0];
	end

	assign prdata = (paddr[2] == REG_IDX_PREMUL_EN) ?
		{{(APB_DW-1){1'b0}}, premul_en_q} : '0;

	// Input request
	assign take = push && !full;
	assign pix  = '{red: red, green: green, blue: blue, alpha: alpha};

	auprem_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.command        (command),
		.first_of_frame (first_of_frame),
		.pix            (pix),
		.premul_en      (premul_en_q),
		.job_push       (job_push),
		.job            (job_in)
	);

	auprem_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wr_data (job_in),
		.rd      (q_take),
		.rd_data (job_out),
		.full    (full),
		.empty   (q_empty)
	);

	auprem_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!q_empty),
		.job        (job_out),
		.job_take   (q_take),
		.pop        (pop),
		.empty      (empty),
		.out_first  (out_first),
		.out_second (out_second),
		.out_third  (out_third),
		.out_fourth (out_fourth),
		.mode       (mode)
	);

endmodule

[rtl/auprem_checker.sv]
`include "assert_macros.svh"

module auprem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_first,
	input logic [7:0] out_second,
	input logic [7:0] out_third,
	input logic [7:0] out_fourth,
	input logic [1:0] mode
);
	import auprem_pkg::*;

	// A waiting result holds until popped
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_first) && $stable(out_second) && $stable(out_third) && $stable(out_fourth) && $stable(mode), "result changed while waiting")

	// Mode is one of the three classes
	`ASSERT_ALWAYS(a_mode_code, clk, arst_n, empty || mode != 2'd3, "invalid mode code")

	// Adjusted transparent pixel is all black
	`ASSERT_IMPLY(a_clear_black, clk, arst_n, !empty && mode == MODE_ADJUST && out_first == ALPHA_CLEAR, out_second == 8'd0 && out_third == 8'd0 && out_fourth == 8'd0, "transparent pixel not black")

	// Adjusted colors never exceed alpha
	`ASSERT_IMPLY(a_color_le_alpha, clk, arst_n, !empty && mode == MODE_ADJUST, out_second <= out_first && out_third <= out_first && out_fourth <= out_first, "color above alpha")

endmodule

bind alpha_unmatte_premultiply auprem_checker u_auprem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_first  (out_first),
	.out_second (out_second),
	.out_third  (out_third),
	.out_fourth (out_fourth),
	.mode       (mode)
);
